@@ rtl/ppl_pkg.sv @@
`default_nettype none
package ppl_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  piece_byte;
        logic        byte_valid;
        logic        piece_last;
        logic [19:0] piece_id;
        logic        piece_flag;
    } t_out_item;

    localparam logic [19:0] ID_MAX = 20'hFFFFF;

    // Wire types of a protobuf tag and the field number that carries a piece.
    localparam logic [2:0]  WT_VARINT   = 3'd0;
    localparam logic [2:0]  WT_FIXED64  = 3'd1;
    localparam logic [2:0]  WT_LEN      = 3'd2;
    localparam logic [2:0]  WT_FIXED32  = 3'd5;
    localparam logic [60:0] FIELD_PIECE = 61'd1;

    // Emit request from the parser datapath to the controller.
    typedef struct packed {
        logic       emit;
        logic       flag;
        logic [6:0] len;
    } t_emit_req;

    // Emit progress from the controller back to the datapath.
    typedef struct packed {
        logic       rd_en;
        logic [5:0] rd_addr;
        logic       done;
    } t_emit_cmd;

endpackage
`default_nettype wire

@@ rtl/ppl_datapath.sv @@
`default_nettype none
// Byte parser: decodes varints and tracks field and submessage bounds. The
// piece store is written here and read under controller command.
module ppl_datapath #(
    parameter int PIECE_BUF_BYTES = 64,
    parameter int LENGTH_BITS     = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire ppl_pkg::t_in_item i_item,
    input  wire ppl_pkg::t_emit_cmd i_cmd,
    output ppl_pkg::t_emit_req     o_req,
    output logic [7:0]             o_rd_data,
    output logic [19:0]            o_id
);
    localparam int AW = (PIECE_BUF_BYTES > 1) ? $clog2(PIECE_BUF_BYTES) : 1;
    localparam logic [LENGTH_BITS-1:0] LMAX = '1;

    typedef enum logic [2:0] {
        PH_TAG, PH_LEN_OPEN, PH_LEN_STR, PH_LEN_SKIP,
        PH_SKIP_VARINT, PH_SKIP_BYTES, PH_STR_BYTES
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic                   r_in_sub, n_in_sub;
    logic [63:0]            r_acc, n_acc;
    logic [6:0]             r_shift, n_shift;
    logic [LENGTH_BITS-1:0] r_sub, n_sub;
    logic [LENGTH_BITS-1:0] r_skip, n_skip;
    logic [6:0]             r_plen, n_plen;
    logic                   r_povf, n_povf;
    logic [19:0]            r_cnt;
    logic [7:0]             r_mem [PIECE_BUF_BYTES];
    logic [7:0]             r_rd;

    logic [7:0]             b;
    logic [63:0]            vfull, part;
    logic                   vdone;
    logic [LENGTH_BITS-1:0] vlen;
    logic                   emit, eflag, wr_en;
    logic [6:0]             elen;

    always_comb begin
        b = i_item.data_byte;
        part = 64'(b[6:0]) << r_shift[5:0];
        vfull = (r_shift < 7'd64) ? (r_acc | part) : r_acc;
        vdone = !b[7];
        vlen = (|(vfull >> LENGTH_BITS)) ? LMAX : vfull[LENGTH_BITS-1:0];

        n_phase = r_phase; n_in_sub = r_in_sub; n_acc = r_acc; n_shift = r_shift;
        n_sub = r_sub; n_skip = r_skip; n_plen = r_plen; n_povf = r_povf;
        emit = 1'b0; eflag = 1'b0; elen = '0; wr_en = 1'b0;

        if (!vdone && r_phase <= PH_SKIP_VARINT) begin
            n_acc = vfull;
            n_shift = (r_shift > 7'd63) ? 7'd70 : r_shift + 7'd7;
        end else if (r_phase <= PH_SKIP_VARINT) begin
            n_acc = '0; n_shift = '0;
        end

        unique case (r_phase)
            PH_TAG: if (vdone) begin
                if (vfull[63:3] == ppl_pkg::FIELD_PIECE && vfull[2:0] == ppl_pkg::WT_LEN)
                    n_phase = r_in_sub ? PH_LEN_STR : PH_LEN_OPEN;
                else begin
                    case (vfull[2:0])
                        ppl_pkg::WT_VARINT: n_phase = PH_SKIP_VARINT;
                        ppl_pkg::WT_FIXED64: begin
                            n_skip = LENGTH_BITS'(8); n_phase = PH_SKIP_BYTES;
                        end
                        ppl_pkg::WT_FIXED32: begin
                            n_skip = LENGTH_BITS'(4); n_phase = PH_SKIP_BYTES;
                        end
                        ppl_pkg::WT_LEN: n_phase = PH_LEN_SKIP;
                        default: n_phase = PH_TAG;
                    endcase
                end
            end
            PH_LEN_OPEN: if (vdone) begin
                n_plen = '0; n_povf = 1'b0; n_phase = PH_TAG;
                if (vlen == '0) begin
                    emit = 1'b1; elen = '0; eflag = 1'b0;
                end else begin
                    n_in_sub = 1'b1; n_sub = vlen;
                end
            end
            PH_LEN_STR: if (vdone) begin
                n_plen = '0; n_povf = 1'b0; n_skip = vlen;
                n_phase = (vlen == '0) ? PH_TAG : PH_STR_BYTES;
            end
            PH_LEN_SKIP: if (vdone) begin
                n_skip = vlen;
                n_phase = (vlen == '0) ? PH_TAG : PH_SKIP_BYTES;
            end
            PH_SKIP_VARINT: if (vdone) n_phase = PH_TAG;
            PH_SKIP_BYTES: begin
                if (r_skip != '0) n_skip = r_skip - LENGTH_BITS'(1);
                if (r_skip <= LENGTH_BITS'(1)) n_phase = PH_TAG;
            end
            PH_STR_BYTES: begin
                if (r_plen < 7'(PIECE_BUF_BYTES)) begin
                    wr_en = 1'b1; n_plen = r_plen + 7'd1;
                end else n_povf = 1'b1;
                if (r_skip != '0) n_skip = r_skip - LENGTH_BITS'(1);
                if (r_skip <= LENGTH_BITS'(1)) n_phase = PH_TAG;
            end
            default: begin n_phase = PH_TAG; n_acc = '0; n_shift = '0; end
        endcase

        if (r_in_sub) begin
            if (r_sub != '0) n_sub = r_sub - LENGTH_BITS'(1);
            if (r_sub <= LENGTH_BITS'(1)) begin
                if (n_phase == PH_STR_BYTES) n_povf = 1'b1;
                n_in_sub = 1'b0; n_phase = PH_TAG; n_acc = '0; n_shift = '0;
                n_skip = '0;
                emit = 1'b1; elen = n_plen; eflag = n_povf;
            end
        end

        if (i_item.stream_end) begin
            if (n_in_sub) begin
                emit = 1'b1; elen = n_plen; eflag = 1'b1;
            end
            n_phase = PH_TAG; n_in_sub = 1'b0; n_acc = '0; n_shift = '0;
            n_sub = '0; n_skip = '0;
        end
        if (emit) begin
            n_plen = '0; n_povf = 1'b0;
        end
    end

    // The id of an emitted piece is latched; the counter advances at once.
    logic [19:0] r_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG; r_in_sub <= 1'b0; r_acc <= '0; r_shift <= '0;
            r_sub <= '0; r_skip <= '0; r_plen <= '0; r_povf <= 1'b0; r_cnt <= '0;
            o_req <= '0; r_id <= '0;
        end else begin
            if (i_take) begin
                r_phase <= n_phase; r_in_sub <= n_in_sub; r_acc <= n_acc;
                r_shift <= n_shift; r_sub <= n_sub; r_skip <= n_skip;
                r_plen <= n_plen; r_povf <= n_povf;
                if (i_item.stream_end) r_cnt <= '0;
                else if (emit && r_cnt != ppl_pkg::ID_MAX) r_cnt <= r_cnt + 20'd1;
                if (emit) r_id <= r_cnt;
                o_req <= '{emit: emit, flag: eflag, len: elen};
            end else if (i_cmd.done) begin
                o_req.emit <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && wr_en) r_mem[r_plen[AW-1:0]] <= b;
        if (i_cmd.rd_en) r_rd <= r_mem[i_cmd.rd_addr[AW-1:0]];
    end

    assign o_rd_data = r_rd;
    assign o_id = r_id;
endmodule
`default_nettype wire

@@ rtl/ppl_ctrl.sv @@
`default_nettype none
// Emit sequencer: reads the piece store into an output register a byte at a
// time, holding each byte while the output stalls until it is taken.
module ppl_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    output logic                    o_take,
    input  wire ppl_pkg::t_emit_req i_req,
    input  wire logic [7:0]         i_rd_data,
    input  wire logic [19:0]        i_id,
    output ppl_pkg::t_emit_cmd      o_cmd,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output ppl_pkg::t_out_item      o_out
);
    typedef enum logic [1:0] {S_PARSE, S_READ, S_LOAD, S_HOLD} t_state;

    t_state      r_state;
    logic [6:0]  r_idx;
    logic        r_valid;
    logic [7:0]  r_byte;
    logic        r_last, r_bv;

    assign o_in_stall = !(r_state == S_PARSE && !i_req.emit);
    assign o_take = i_in_valid && !o_in_stall;

    logic out_take;
    assign out_take = r_valid && !i_out_stall;

    always_comb begin
        o_cmd.rd_en = (r_state == S_READ);
        o_cmd.rd_addr = r_idx[5:0];
        o_cmd.done = (r_state == S_HOLD) && out_take && r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_PARSE; r_idx <= '0; r_valid <= 1'b0;
            r_last <= 1'b0; r_bv <= 1'b0;
        end else begin
            unique case (r_state)
                S_PARSE: if (i_req.emit) begin
                    r_idx <= '0;
                    if (i_req.len == '0) begin
                        r_bv <= 1'b0; r_last <= 1'b1; r_byte <= '0;
                        r_valid <= 1'b1; r_state <= S_HOLD;
                    end else r_state <= S_READ;
                end
                S_READ: r_state <= S_LOAD;
                S_LOAD: begin
                    r_byte <= i_rd_data; r_bv <= 1'b1;
                    r_last <= (r_idx + 7'd1 == i_req.len);
                    r_idx <= r_idx + 7'd1;
                    r_valid <= 1'b1; r_state <= S_HOLD;
                end
                S_HOLD: if (out_take) begin
                    r_valid <= 1'b0;
                    r_state <= r_last ? S_PARSE : S_READ;
                end
                default: r_state <= S_PARSE;
            endcase
        end
    end

    assign o_out_valid = r_valid;
    always_comb begin
        o_out.piece_byte = r_byte;
        o_out.byte_valid = r_bv;
        o_out.piece_last = r_last;
        o_out.piece_id = i_id;
        o_out.piece_flag = i_req.flag;
    end

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_state == S_HOLD) else $error("result not in hold");
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> !r_valid) else $error("input taken during emit");
    a_done_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.done |-> i_req.emit) else $error("done without request");
endmodule
`default_nettype wire

@@ rtl/protobuf_piece_list_parser.sv @@
`default_nettype none
// A byte that closes a piece registers an emit request; the first result follows
// the controller's start, store read and load steps. Throughput: one input byte per
// cycle while parsing; input stalls during an emit: a start, then per piece byte a
// store read, load and transfer (waiting while the output stalls), the store read
// port being registered. An empty piece takes a start and a transfer.
// Reset: synchronous active-low i_rst_n clears parse state and piece count.
module protobuf_piece_list_parser #(
    parameter int PIECE_BUF_BYTES = 64,
    parameter int LENGTH_BITS     = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire ppl_pkg::t_in_item   i_data,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output ppl_pkg::t_out_item       o_data
);
    // Handshake and emit status between the controller and the parser.
    logic               take;
    ppl_pkg::t_emit_req req;
    ppl_pkg::t_emit_cmd cmd;
    logic [7:0]         rd_data;
    logic [19:0]        id;

    // The parser consumes one byte per accepted transfer.
    ppl_datapath #(.PIECE_BUF_BYTES(PIECE_BUF_BYTES), .LENGTH_BITS(LENGTH_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take), .i_item(i_data),
        .i_cmd(cmd), .o_req(req), .o_rd_data(rd_data), .o_id(id)
    );

    // The controller replays the buffered piece as output transfers.
    ppl_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_valid), .o_in_stall(o_stall),
        .o_take(take), .i_req(req), .i_rd_data(rd_data), .i_id(id), .o_cmd(cmd),
        .o_out_valid(o_valid), .i_out_stall(i_stall), .o_out(o_data)
    );
endmodule
`default_nettype wire

@@ bench/protobuf_piece_list_parser_tb.sv @@
`timescale 1ns / 100ps
`default_nettype none

// Holds the expected piece bytes and compares each output transfer against the oldest one.
class piece_scoreboard;
    typedef enum int {
        PH_TAG, PH_LEN_OPEN, PH_LEN_STR, PH_LEN_SKIP, PH_SKIP_VARINT, PH_SKIP_BYTES,
        PH_STR_BYTES
    } t_phase;

    localparam int MAX_BYTES = 64;
    localparam logic [63:0] LEN_MAX = 64'hFFFF_FFFF;

    t_phase      phase;
    bit          in_sub;
    logic [63:0] accum;
    int          shift;
    logic [63:0] sub_left;
    logic [63:0] skip_left;
    logic [7:0]  store [MAX_BYTES];
    int          plen;
    bit          overflow;
    logic [19:0] count;
    ppl_pkg::t_out_item pending[$];
    int          errors;

    function new();
        errors = 0;
        reset_all();
    endfunction

    function void reset_parse();
        phase = PH_TAG;
        in_sub = 0;
        accum = 0;
        shift = 0;
        sub_left = 0;
        skip_left = 0;
        plen = 0;
        overflow = 0;
    endfunction

    function void reset_all();
        reset_parse();
        count = 0;
    endfunction

    // Returns 1 when the varint is complete; the value lands in val.
    function bit take_varint(logic [7:0] b, output logic [63:0] val);
        val = 0;
        if (shift < 64) accum = accum | (64'(b[6:0]) << shift);
        if (b[7]) begin
            shift = (shift + 7 > 70) ? 70 : shift + 7;
            return 0;
        end
        val = accum;
        accum = 0;
        shift = 0;
        return 1;
    endfunction

    function void queue_piece(bit cut);
        ppl_pkg::t_out_item r;
        bit flag;
        flag = overflow | cut;
        if (plen == 0) begin
            r = '{piece_byte: 8'h00, byte_valid: 1'b0, piece_last: 1'b1,
                  piece_id: count, piece_flag: flag};
            pending.insert(pending.size(), r);
        end else begin
            for (int k = 0; k < plen; k++) begin
                r = '{piece_byte: store[k], byte_valid: 1'b1, piece_last: (k == plen - 1),
                      piece_id: count, piece_flag: flag};
                pending.insert(pending.size(), r);
            end
        end
        if (count != ppl_pkg::ID_MAX) count++;
        plen = 0;
        overflow = 0;
    endfunction

    // Advances the parser by one accepted input byte.
    function void note_input(ppl_pkg::t_in_item it);
        logic [63:0] v;
        logic [7:0]  b;
        bit          was_sub;
        b = it.data_byte;
        was_sub = in_sub;
        case (phase)
            PH_TAG: if (take_varint(b, v)) begin
                if (v[63:3] == ppl_pkg::FIELD_PIECE && v[2:0] == ppl_pkg::WT_LEN) begin
                    phase = in_sub ? PH_LEN_STR : PH_LEN_OPEN;
                end else begin
                    case (v[2:0])
                        ppl_pkg::WT_VARINT: phase = PH_SKIP_VARINT;
                        ppl_pkg::WT_FIXED64: begin skip_left = 8; phase = PH_SKIP_BYTES; end
                        ppl_pkg::WT_FIXED32: begin skip_left = 4; phase = PH_SKIP_BYTES; end
                        ppl_pkg::WT_LEN: phase = PH_LEN_SKIP;
                        default: phase = PH_TAG;
                    endcase
                end
            end
            PH_LEN_OPEN: if (take_varint(b, v)) begin
                if (v > LEN_MAX) v = LEN_MAX;
                plen = 0;
                overflow = 0;
                phase = PH_TAG;
                if (v == 0) begin
                    queue_piece(0);
                end else begin
                    in_sub = 1;
                    sub_left = v;
                end
            end
            PH_LEN_STR: if (take_varint(b, v)) begin
                if (v > LEN_MAX) v = LEN_MAX;
                plen = 0;
                overflow = 0;
                skip_left = v;
                phase = (v == 0) ? PH_TAG : PH_STR_BYTES;
            end
            PH_LEN_SKIP: if (take_varint(b, v)) begin
                if (v > LEN_MAX) v = LEN_MAX;
                skip_left = v;
                phase = (v == 0) ? PH_TAG : PH_SKIP_BYTES;
            end
            PH_SKIP_VARINT: if (take_varint(b, v)) phase = PH_TAG;
            PH_SKIP_BYTES: begin
                if (skip_left > 0) skip_left--;
                if (skip_left == 0) phase = PH_TAG;
            end
            PH_STR_BYTES: begin
                if (plen < MAX_BYTES) begin
                    store[plen] = b;
                    plen++;
                end else begin
                    overflow = 1;
                end
                if (skip_left > 0) skip_left--;
                if (skip_left == 0) phase = PH_TAG;
            end
            default: phase = PH_TAG;
        endcase
        // The submessage bound cuts whatever item is open inside it.
        if (was_sub) begin
            if (sub_left > 0) sub_left--;
            if (sub_left == 0) begin
                if (phase == PH_STR_BYTES) overflow = 1;
                in_sub = 0;
                phase = PH_TAG;
                accum = 0;
                shift = 0;
                skip_left = 0;
                queue_piece(0);
            end
        end
        if (it.stream_end) begin
            if (in_sub) queue_piece(1);
            reset_all();
        end
    endfunction

    function void check_result(ppl_pkg::t_out_item got);
        ppl_pkg::t_out_item exp;
        if (pending.size() == 0) begin
            $error("unexpected piece transfer: %p", got);
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (got.piece_byte !== exp.piece_byte) begin
            $error("piece_byte: expected %0h, got %0h", exp.piece_byte, got.piece_byte);
            errors++;
        end
        if (got.byte_valid !== exp.byte_valid) begin
            $error("byte_valid: expected %0d, got %0d", exp.byte_valid, got.byte_valid);
            errors++;
        end
        if (got.piece_last !== exp.piece_last) begin
            $error("piece_last: expected %0d, got %0d", exp.piece_last, got.piece_last);
            errors++;
        end
        if (got.piece_id !== exp.piece_id) begin
            $error("piece_id: expected %0d, got %0d", exp.piece_id, got.piece_id);
            errors++;
        end
        if (got.piece_flag !== exp.piece_flag) begin
            $error("piece_flag: expected %0d, got %0d", exp.piece_flag, got.piece_flag);
            errors++;
        end
    endfunction
endclass

module protobuf_piece_list_parser_tb;

    // Watchdog: cycles without any transfer. The slowest stretch is a 64-byte
    // emit, with a store read, load and transfer per byte and the receiver stalling at random.
    localparam int IDLE_LIMIT = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    ppl_pkg::t_in_item  i_data;
    logic               o_valid;
    logic               i_stall;
    ppl_pkg::t_out_item o_data;

    piece_scoreboard pieces;
    byte unsigned    stream_bytes[$];   // encoded bytes waiting to be sent
    bit              stream_ends[$];    // matching last-byte markers
    bit              quiet;             // no idling on either side while set
    int              idle_cycles;

    protobuf_piece_list_parser dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Byte-level helpers that build the encoded stream.
    task automatic push_byte(input byte unsigned b, input bit last = 0);
        stream_bytes.insert(stream_bytes.size(), b);
        stream_ends.insert(stream_ends.size(), last);
    endtask

    task automatic push_varint(input logic [63:0] v, input int pad = 0);
        // pad adds redundant continuation bytes, which exercises long varints.
        for (int k = 0; k < 10 + pad; k++) begin
            if (v < 128 && k >= pad && (v >> 7) == 0) begin
                push_byte(v[7:0]);
                return;
            end
            push_byte({1'b1, v[6:0]});
            v = v >> 7;
        end
        push_byte(8'h00);
    endtask

    function automatic int varint_size(logic [63:0] v);
        int n;
        n = 1;
        while (v >= 128) begin
            v = v >> 7;
            n++;
        end
        return n;
    endfunction

    // A piece submessage with a random mix of fields inside; total body length
    // is computed first so the outer length is exact unless cut is requested.
    task automatic push_piece(input int str_len, input int extra, input int cut);
        byte unsigned body[$];
        logic [63:0] v;
        int kind;
        for (int e = 0; e <= extra; e++) begin
            kind = (e == extra) ? 0 : $urandom_range(0, 4);
            case (kind)
                0: begin   // string field 1
                    body.insert(body.size(), 8'h0A);
                    v = str_len;
                    while (v >= 128) begin
                        body.insert(body.size(), {1'b1, v[6:0]});
                        v = v >> 7;
                    end
                    body.insert(body.size(), v[7:0]);
                    for (int k = 0; k < str_len; k++)
                        body.insert(body.size(), 8'($urandom_range(0, 255)));
                end
                1: begin   // float score, wire type 5
                    body.insert(body.size(), 8'h15);
                    repeat (4) body.insert(body.size(), 8'($urandom_range(0, 255)));
                end
                2: begin   // varint type field
                    body.insert(body.size(), 8'h18);
                    body.insert(body.size(), 8'hFF);
                    body.insert(body.size(), 8'($urandom_range(0, 127)));
                end
                3: begin   // fixed64
                    body.insert(body.size(), 8'h21);
                    repeat (8) body.insert(body.size(), 8'($urandom_range(0, 255)));
                end
                default: begin   // unknown wire type
                    body.insert(body.size(),
                                {5'($urandom_range(1, 31)), 3'($urandom_range(3, 4))});
                end
            endcase
        end
        push_byte(8'h0A);
        push_varint(body.size() - cut);
        foreach (body[k]) if (k < body.size() - cut) push_byte(body[k]);
    endtask

    task automatic build_directed();
        // Empty submessage, then a piece with no string.
        push_byte(8'h0A); push_byte(8'h00);
        push_byte(8'h0A); push_byte(8'h02); push_byte(8'h10); push_byte(8'h7F);
        // One-byte piece whose byte is 0xFF.
        push_byte(8'h0A); push_byte(8'h03); push_byte(8'h0A); push_byte(8'h01);
        push_byte(8'hFF);
        // Top-level skips: varint, fixed64, fixed32, length-delimited, unknown.
        push_byte(8'h08); push_byte(8'h80); push_byte(8'h00);
        push_byte(8'h11); repeat (8) push_byte(8'h00);
        push_byte(8'h15); repeat (4) push_byte(8'hFF);
        push_byte(8'h12); push_byte(8'h01); push_byte(8'h55);
        push_byte(8'h1B);
        // Repeated string: the second one wins.
        push_byte(8'h0A); push_byte(8'h07);
        push_byte(8'h0A); push_byte(8'h01); push_byte(8'h41);
        push_byte(8'h0A); push_byte(8'h02); push_byte(8'h42); push_byte(8'h00);
        // Long piece, truncated, and a string cut by the submessage bound.
        push_piece(70, 0, 0);
        push_piece(5, 0, 2);
        // Over-long varint length saturates; stream end cuts the open piece.
        push_byte(8'h0A); push_varint(64'hFFFF_FFFF_FFFF, 3);
        push_byte(8'h0A); push_byte(8'h02); push_byte(8'h61); push_byte(8'h62, 1);
        // Stream end in a top-level item with ids from zero afterward.
        push_byte(8'h08); push_byte(8'hFF, 1);
    endtask

    task automatic build_random();
        int r;
        while (stream_bytes.size() < 200) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                push_piece(($urandom_range(0, 9) == 0) ? $urandom_range(60, 70)
                           : $urandom_range(0, 8), $urandom_range(0, 2),
                           ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0);
            end else if (r < 85) begin
                push_byte($urandom_range(0, 255));
            end else if (r < 95) begin
                push_byte(8'h12); push_byte(8'h02);
                push_byte($urandom_range(0, 255)); push_byte($urandom_range(0, 255));
            end else begin
                push_byte($urandom_range(0, 255), 1);
            end
        end
        push_byte(8'h00, 1);
    endtask

    // Sends the stream; the pause waits for all pieces after the directed part.
    task automatic send_stream(input int pause_at);
        int sent;
        sent = 0;
        while (stream_bytes.size() > 0) begin
            if (sent == pause_at) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pieces.pending.size() > 0) @(posedge i_clk);
                repeat (8) @(posedge i_clk);
            end
            quiet = (sent >= 60 && sent < 130);
            if (!quiet && $urandom_range(0, 99) < 35) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_valid <= 1'b1;
                i_data  <= '{data_byte: stream_bytes[0], stream_end: stream_ends[0]};
                @(posedge i_clk);
                while (o_stall) @(posedge i_clk);
                void'(stream_bytes.pop_front());
                void'(stream_ends.pop_front());
                sent++;
            end
        end
        i_valid <= 1'b0;
    endtask

    // Scoreboard side: sample at the edge, then pick the next stall value.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) pieces.note_input(i_data);
            if (o_valid && !i_stall) pieces.check_result(o_data);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
        i_stall <= !quiet && ($urandom_range(0, 99) < 35);
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int directed_len;
        pieces = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        i_stall = 1'b0;
        quiet = 1'b0;
        idle_cycles = 0;
        build_directed();
        directed_len = stream_bytes.size();
        build_random();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_stream(directed_len);
        @(posedge i_clk);
        while (pieces.pending.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (pieces.errors == 0 && pieces.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

`default_nettype wire
